### design/tts_pkg.sv
// shared types and constants of the timer table scheduler
package tts_pkg;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_RUN_AFTER  = 3'd1,
		CMD_RUN_EVERY  = 3'd2,
		CMD_RESCHEDULE = 3'd3,
		CMD_CANCEL     = 3'd4,
		CMD_STOP       = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_STOPPED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_APPLY,
		FSM_FINAL,
		FSM_EMIT,
		FSM_WAIT
	} fsm_t;

	localparam logic [30:0] NO_TIMEOUT = 31'h7FFF_FFFF;
	localparam logic [31:0] SIGN32     = 32'h8000_0000;
	localparam int unsigned RESULT_LIMIT = 16;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the command word, clear the tag queue and expiry count
		logic scan_start; // restart slot scan at index zero
		logic scan_step;  // examine one slot
		logic apply;      // carry out the command on the found slot
		logic tick_time;  // advance time on a tick command
		logic emit;       // load the output register
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic   scan_done;
		logic   is_tick;
		logic   due_found;
		logic   accepting;
		logic   out_busy;
	} sts_t;

endpackage

### design/tts_if.sv
// valid/ready channel interfaces for command and result words
interface tts_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [30:0] delay_ms;
	logic [31:0] timer_id;
	logic [15:0] task_tag;
	modport source (output valid, command, delay_ms, timer_id, task_tag, input ready);
	modport sink (input valid, command, delay_ms, timer_id, task_tag, output ready);
endinterface

interface tts_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] new_timer_id;
	logic        expired_valid;
	logic [15:0] expired_tag;
	logic [30:0] next_timeout;
	logic        last;
	modport source (output valid, status, new_timer_id, expired_valid, expired_tag,
		next_timeout, last, input ready);
	modport sink (input valid, status, new_timer_id, expired_valid, expired_tag,
		next_timeout, last, output ready);
endinterface

### design/tts_ctrl.sv
// controller state machine of the timer table scheduler
module tts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  tts_pkg::sts_t sts,
	output tts_pkg::ctl_t ctl,
	output logic          in_ready
);
	tts_pkg::fsm_t state_q, state_d;
	logic [4:0] emitted_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tts_pkg::FSM_IDLE: if (in_fire) state_d = tts_pkg::FSM_SCAN;
			tts_pkg::FSM_SCAN: if (sts.scan_done) state_d = tts_pkg::FSM_APPLY;
			tts_pkg::FSM_APPLY: begin
				if (sts.is_tick && sts.due_found && sts.accepting &&
					emitted_q < 5'(tts_pkg::RESULT_LIMIT - 1))
					state_d = tts_pkg::FSM_SCAN;
				else
					state_d = tts_pkg::FSM_FINAL;
			end
			// closing pass over the final table for the next timeout
			tts_pkg::FSM_FINAL: if (sts.scan_done) state_d = tts_pkg::FSM_WAIT;
			tts_pkg::FSM_WAIT: if (!sts.out_busy) state_d = tts_pkg::FSM_EMIT;
			tts_pkg::FSM_EMIT: state_d = tts_pkg::FSM_IDLE;
			default: state_d = tts_pkg::FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		in_ready = 1'b0;
		case (state_q)
			tts_pkg::FSM_IDLE: begin
				in_ready = !sts.out_busy;
				ctl.load = in_fire;
				ctl.tick_time = in_fire;
				ctl.scan_start = in_fire;
			end
			tts_pkg::FSM_SCAN: ctl.scan_step = 1'b1;
			tts_pkg::FSM_APPLY: begin
				ctl.apply = 1'b1;
				ctl.scan_start = 1'b1;
			end
			tts_pkg::FSM_FINAL: ctl.scan_step = 1'b1;
			tts_pkg::FSM_WAIT: ctl.scan_step = 1'b0;
			tts_pkg::FSM_EMIT: ctl.emit = 1'b1;
			default: ctl = '0;
		endcase
	end

	// count of expiries in this tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tts_pkg::FSM_IDLE;
			emitted_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) emitted_q <= '0;
			else if (ctl.apply && sts.is_tick && sts.due_found && sts.accepting)
				emitted_q <= emitted_q + 5'd1;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == tts_pkg::FSM_IDLE) else $error("ready outside idle");
	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= 5'(tts_pkg::RESULT_LIMIT)) else $error("too many expiries");
	a_scan_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == tts_pkg::FSM_SCAN) else $error("load without scan");
endmodule

### design/tts_datapath.sv
// slot table, scanner and result queue of the timer table scheduler
module tts_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tts_pkg::ctl_t ctl,
	output tts_pkg::sts_t sts,
	tts_cmd_if.sink       cmd,
	tts_res_if.source     res
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// slot storage
	logic [ENTRIES-1:0] valid_q;
	logic [31:0] deadline_q [ENTRIES];
	logic [31:0] id_q       [ENTRIES];
	logic [30:0] period_q   [ENTRIES];
	logic        periodic_q [ENTRIES];
	logic [15:0] tag_q      [ENTRIES];

	logic [31:0] now_q, next_id_q;
	logic        accepting_q;

	// captured command word
	logic [2:0]  cmd_q;
	logic [30:0] delay_q;
	logic [31:0] tid_q;
	logic [15:0] tagin_q;

	// scan state
	logic [CW-1:0] idx_q;
	logic          free_hit_q, id_hit_q, due_hit_q, any_q;
	logic [IW-1:0] free_idx_q, id_idx_q, due_idx_q;
	logic [31:0]   due_key_q, due_id_q, min_key_q;

	// tick result queue
	logic [15:0] tagq_q [tts_pkg::RESULT_LIMIT];
	logic [4:0]  qn_q, qrd_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_nid_q;
	logic        out_ev_q;
	logic [15:0] out_tag_q;
	logic [30:0] out_nt_q;
	logic        out_last_q;
	logic        emitting_q;
	logic [30:0] nt_q;
	logic [1:0]  st_q;
	logic [31:0] nid_q;

	logic [IW-1:0] si;
	logic [31:0] d, key;
	logic due_i;
	logic [31:0] bd;
	logic [30:0] nt_calc;
	logic is_tick;

	assign si = idx_q[IW-1:0];
	assign d = deadline_q[si] - now_q;
	assign key = d ^ tts_pkg::SIGN32;
	assign due_i = (d == 32'd0) || d[31];
	assign is_tick = cmd_q == tts_pkg::CMD_TICK;
	// next timeout from the closing scan of the final table
	assign bd = min_key_q ^ tts_pkg::SIGN32;
	assign nt_calc = !any_q ? tts_pkg::NO_TIMEOUT :
		((bd == 32'd0 || bd[31]) ? 31'd0 : bd[30:0]);

	assign sts.scan_done = idx_q == CW'(ENTRIES - 1) && ctl.scan_step;
	assign sts.is_tick = is_tick;
	assign sts.due_found = due_hit_q;
	assign sts.accepting = accepting_q;
	assign sts.out_busy = emitting_q;

	// scanner: one slot per cycle
	always_ff @(posedge clk) begin
		if (ctl.scan_start) begin
			idx_q <= '0;
			free_hit_q <= 1'b0; id_hit_q <= 1'b0; due_hit_q <= 1'b0; any_q <= 1'b0;
		end else if (ctl.scan_step) begin
			idx_q <= idx_q + CW'(1);
			if (valid_q[si]) begin
				if (!any_q || key < min_key_q) min_key_q <= key;
				any_q <= 1'b1;
				if (!id_hit_q && id_q[si] == tid_q) begin
					id_hit_q <= 1'b1; id_idx_q <= si;
				end
				if (due_i && (!due_hit_q || key < due_key_q ||
					(key == due_key_q && id_q[si] < due_id_q))) begin
					due_hit_q <= 1'b1; due_idx_q <= si;
					due_key_q <= key; due_id_q <= id_q[si];
				end
			end else if (!free_hit_q) begin
				free_hit_q <= 1'b1; free_idx_q <= si;
			end
		end
	end

	// table and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q <= '0;
			next_id_q <= '0;
			accepting_q <= 1'b1;
			qn_q <= '0;
		end else begin
			if (ctl.load) qn_q <= '0;
			if (ctl.tick_time && cmd.command == tts_pkg::CMD_TICK) now_q <= now_q + 32'd1;
			if (ctl.apply) begin
				case (cmd_q)
					tts_pkg::CMD_TICK: begin
						if (due_hit_q && accepting_q && qn_q < 5'(tts_pkg::RESULT_LIMIT)) begin
							qn_q <= qn_q + 5'd1;
							if (periodic_q[due_idx_q])
								deadline_q[due_idx_q] <= now_q + {1'b0, period_q[due_idx_q]};
							else
								valid_q[due_idx_q] <= 1'b0;
						end
					end
					tts_pkg::CMD_RUN_AFTER, tts_pkg::CMD_RUN_EVERY: begin
						if (accepting_q && free_hit_q) begin
							next_id_q <= next_id_q + 32'd1;
							valid_q[free_idx_q] <= 1'b1;
							id_q[free_idx_q] <= next_id_q;
							tag_q[free_idx_q] <= tagin_q;
							if (cmd_q == tts_pkg::CMD_RUN_AFTER) begin
								deadline_q[free_idx_q] <= now_q + {1'b0, delay_q};
								periodic_q[free_idx_q] <= 1'b0;
								period_q[free_idx_q] <= '0;
							end else begin
								deadline_q[free_idx_q] <= now_q;
								periodic_q[free_idx_q] <= 1'b1;
								period_q[free_idx_q] <= (delay_q == '0) ? 31'd1 : delay_q;
							end
						end
					end
					tts_pkg::CMD_RESCHEDULE: begin
						if (accepting_q) begin
							next_id_q <= next_id_q + 32'd1;
							if (id_hit_q) begin
								id_q[id_idx_q] <= next_id_q;
								deadline_q[id_idx_q] <= now_q + {1'b0, delay_q};
								periodic_q[id_idx_q] <= 1'b0;
								period_q[id_idx_q] <= '0;
							end
						end
					end
					tts_pkg::CMD_CANCEL: if (id_hit_q) valid_q[id_idx_q] <= 1'b0;
					tts_pkg::CMD_STOP: accepting_q <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	// command capture, per-command status and queue of expired tags
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd.command; delay_q <= cmd.delay_ms;
			tid_q <= cmd.timer_id; tagin_q <= cmd.task_tag;
		end
		if (ctl.apply) begin
			st_q <= tts_pkg::ST_OK;
			nid_q <= '0;
			case (cmd_q)
				tts_pkg::CMD_TICK:
					if (due_hit_q && accepting_q && qn_q < 5'(tts_pkg::RESULT_LIMIT))
						tagq_q[qn_q[3:0]] <= tag_q[due_idx_q];
				tts_pkg::CMD_RUN_AFTER, tts_pkg::CMD_RUN_EVERY:
					if (!accepting_q) st_q <= tts_pkg::ST_STOPPED;
					else if (!free_hit_q) st_q <= tts_pkg::ST_FULL;
					else nid_q <= next_id_q;
				tts_pkg::CMD_RESCHEDULE:
					if (!accepting_q) st_q <= tts_pkg::ST_STOPPED;
					else if (!id_hit_q) st_q <= tts_pkg::ST_NOT_FOUND;
					else nid_q <= next_id_q;
				tts_pkg::CMD_CANCEL:
					if (!id_hit_q) st_q <= tts_pkg::ST_NOT_FOUND;
				default: ;
			endcase
		end
	end

	// output stage: walks the tag queue, one word per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			emitting_q <= 1'b0;
			qrd_q <= '0;
		end else begin
			if (ctl.emit) begin
				emitting_q <= 1'b1;
				qrd_q <= '0;
				nt_q <= nt_calc;
			end else if (emitting_q && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
				out_status_q <= st_q;
				out_nid_q <= nid_q;
				out_nt_q <= nt_q;
				if (is_tick && qn_q != 5'd0) begin
					out_ev_q <= 1'b1;
					out_tag_q <= tagq_q[qrd_q[3:0]];
					out_last_q <= (qrd_q + 5'd1) == qn_q;
					qrd_q <= qrd_q + 5'd1;
					if ((qrd_q + 5'd1) == qn_q) emitting_q <= 1'b0;
				end else begin
					out_ev_q <= 1'b0;
					out_tag_q <= '0;
					out_last_q <= 1'b1;
					emitting_q <= 1'b0;
				end
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.status = out_status_q;
	assign res.new_timer_id = out_nid_q;
	assign res.expired_valid = out_ev_q;
	assign res.expired_tag = out_tag_q;
	assign res.next_timeout = out_nt_q;
	assign res.last = out_last_q;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qn_q <= 5'(tts_pkg::RESULT_LIMIT)) else $error("tag queue overflow");
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emitting_q && is_tick && qn_q != 5'd0 |-> qrd_q < qn_q) else $error("queue overread");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!accepting_q |=> !accepting_q) else $error("accepting came back");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q) else $error("result dropped");
endmodule

### design/timer_table_scheduler.sv
// top level of the timer table scheduler
// flow: accept, scan rounds each ending in an apply, a closing scan, wait for the output stage, emit
// scan rounds: one for a non-tick command, min(k + 1, 16) for a tick expiring k timers
// next word accepted in the cycle after the last result word is loaded,
// so a new command never overlaps the processing of the previous one
// reset: slot valid bits, time, id counter cleared, block accepting
module timer_table_scheduler #(
	parameter int ENTRIES = 16
) (
	input logic       clk,
	input logic       arst_n,
	tts_cmd_if.sink   cmd,
	tts_res_if.source res
);
	tts_pkg::ctl_t ctl;
	tts_pkg::sts_t sts;
	logic          in_ready;
	logic          in_fire;

	assign in_fire = cmd.valid && in_ready;
	assign cmd.ready = in_ready;

	// sequencer
	tts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .sts(sts), .ctl(ctl),
		.in_ready(in_ready)
	);

	// table and output stage
	tts_datapath #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .cmd(cmd), .res(res)
	);
endmodule
